### rtl/core/gpt_hv_pkg.sv
// Shared constants, types and helper functions for the GPT header validator.
// No dependencies; imported by gpt_header_validator.
package gpt_hv_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int END_BYTES    = 2 * SECTOR_BYTES;
  localparam int POS_W        = $clog2(END_BYTES) + 1;
  localparam int OFF_W        = $clog2(SECTOR_BYTES);

  localparam int MBR_TABLE_START = 446;
  localparam int MBR_TABLE_END   = MBR_TABLE_START + 64;
  localparam int BOOT_SIG_AT     = 510;
  localparam int HDR_MIN         = 92;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [7:0]  BOOT_LO   = 8'h55;
  localparam logic [7:0]  BOOT_HI   = 8'hAA;
  localparam logic [7:0]  TYPE_PROT = 8'hEE;
  localparam logic [63:0] EFI_SIG   = 64'h5452_4150_2049_4645;

  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 40;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [OFF_W-1:0] off_t;

  typedef enum logic [2:0] {
    FAIL_NONE      = 3'd0,
    FAIL_BOOT_SIG  = 3'd1,
    FAIL_NO_PROT   = 3'd2,
    FAIL_SIGNATURE = 3'd3,
    FAIL_SIZE      = 3'd4,
    FAIL_CRC       = 3'd5
  } fail_code_t;

  // One byte of reflected CRC-32, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Expected byte of the "EFI PART" signature at header offset 0..7.
  function automatic logic [7:0] efi_sig_byte(input logic [2:0] idx);
    return EFI_SIG[{idx, 3'b000} +: 8];
  endfunction

endpackage

### rtl/core/gpt_header_validator.sv
// GPT header validator: checks MBR boot signature, protective entry, GPT
// header signature, size and CRC-32 over a byte stream of sectors 0 and 1.
// Depends on gpt_hv_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata = data_byte, s_tuser = restart
//  m_*     | out | m_tvalid/m_tready | m_tdata = table_valid, fail_code, crc
//
// One byte is taken per cycle; the header fields and the CRC are updated by
// a single byte-wide CRC step in the same cycle, so the rate is one byte per
// clock while the input is not stalled. The verdict is written to the output
// register at the edge that takes the last byte of sector 1 and is offered on
// m_* from the next cycle on. Reset (rst, synchronous) clears the check so the
// first byte counts as byte 0. The input is stalled only while a verdict waits
// in the output register and the sink is not ready to take it.
module gpt_header_validator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [gpt_hv_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] data_byte
  input  logic                             s_tuser,  // [0] restart
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [gpt_hv_pkg::M_DATA_W-1:0]  m_tdata   // [0] table_valid, [3:1] fail_code,
                                                     // [35:4] computed_crc, [39:36] zero
);
  import gpt_hv_pkg::*;

  // Running check state.
  pos_t        byte_position;
  logic [31:0] crc_register;
  logic        boot_sig_ok;
  logic        protective_seen;
  logic        signature_ok;
  logic [31:0] header_length;
  logic [31:0] stored_crc;

  // Next values.
  pos_t        byte_position_next;
  logic [31:0] crc_register_next;
  logic        boot_sig_ok_next;
  logic        protective_seen_next;
  logic        signature_ok_next;
  logic [31:0] header_length_next;
  logic [31:0] stored_crc_next;

  // State as seen by the current byte, after an optional restart.
  pos_t        eff_pos;
  logic [31:0] eff_crc;
  logic        eff_boot;
  logic        eff_prot;
  logic        eff_sig;
  logic [31:0] eff_hlen;
  logic [31:0] eff_scrc;

  logic        accept;
  logic        active;
  logic        last_byte;
  off_t        off;
  logic [7:0]  b;
  logic [7:0]  crc_in;
  logic [3:0]  mbr_rel;

  logic        size_ok;
  logic [31:0] crc_final;
  fail_code_t  code;

  // Output register.
  logic        table_valid;
  fail_code_t  fail_code;
  logic [31:0] computed_crc;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign b        = s_tdata;

  always_comb begin
    if (s_tuser) begin
      eff_pos  = '0;
      eff_crc  = CRC_INIT;
      eff_boot = 1'b0;
      eff_prot = 1'b0;
      eff_sig  = 1'b1;
      eff_hlen = '0;
      eff_scrc = '0;
    end else begin
      eff_pos  = byte_position;
      eff_crc  = crc_register;
      eff_boot = boot_sig_ok;
      eff_prot = protective_seen;
      eff_sig  = signature_ok;
      eff_hlen = header_length;
      eff_scrc = stored_crc;
    end
  end

  assign active    = eff_pos < pos_t'(END_BYTES);
  assign off       = off_t'(eff_pos - pos_t'(SECTOR_BYTES));
  assign mbr_rel   = 4'(eff_pos - pos_t'(MBR_TABLE_START));
  assign last_byte = (eff_pos == pos_t'(END_BYTES - 1));

  always_comb begin
    byte_position_next   = eff_pos + pos_t'(1);
    crc_register_next    = eff_crc;
    boot_sig_ok_next     = eff_boot;
    protective_seen_next = eff_prot;
    signature_ok_next    = eff_sig;
    header_length_next   = eff_hlen;
    stored_crc_next      = eff_scrc;
    crc_in               = b;

    if (eff_pos < pos_t'(SECTOR_BYTES)) begin
      // Sector 0: boot signature and the protective MBR entry type bytes.
      if (eff_pos == pos_t'(BOOT_SIG_AT)) begin
        boot_sig_ok_next = (b == BOOT_LO);
      end else if (eff_pos == pos_t'(BOOT_SIG_AT + 1)) begin
        boot_sig_ok_next = eff_boot && (b == BOOT_HI);
      end
      if (eff_pos >= pos_t'(MBR_TABLE_START) && eff_pos < pos_t'(MBR_TABLE_END) &&
          mbr_rel == 4'd4 && b == TYPE_PROT) begin
        protective_seen_next = 1'b1;
      end
    end else begin
      // Sector 1: GPT header fields and the running CRC.
      if (off < off_t'(8) && b != efi_sig_byte(off[2:0])) begin
        signature_ok_next = 1'b0;
      end
      if (off >= off_t'(12) && off < off_t'(16)) begin
        header_length_next = eff_hlen | ({24'd0, b} << {off[1:0], 3'b000});
      end
      if (off >= off_t'(16) && off < off_t'(20)) begin
        stored_crc_next = eff_scrc | ({24'd0, b} << {off[1:0], 3'b000});
        crc_in          = 8'd0;
      end
      // The size is known once byte 15 is in, so the first 16 bytes always count.
      if (off < off_t'(16) || 32'(off) < eff_hlen) begin
        crc_register_next = crc_byte(eff_crc, crc_in);
      end
    end
  end

  // Verdict for the last byte, taken from the updated state.
  assign crc_final = crc_register_next ^ CRC_INIT;
  assign size_ok   = (header_length_next >= 32'(HDR_MIN)) &&
                     (header_length_next <= 32'(SECTOR_BYTES));

  always_comb begin
    if (!boot_sig_ok_next) begin
      code = FAIL_BOOT_SIG;
    end else if (!protective_seen_next) begin
      code = FAIL_NO_PROT;
    end else if (!signature_ok_next) begin
      code = FAIL_SIGNATURE;
    end else if (!size_ok) begin
      code = FAIL_SIZE;
    end else if (crc_final != stored_crc_next) begin
      code = FAIL_CRC;
    end else begin
      code = FAIL_NONE;
    end
  end

  // Check state: only an accepted byte inside the two sectors moves it.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      crc_register    <= CRC_INIT;
      boot_sig_ok     <= 1'b0;
      protective_seen <= 1'b0;
      signature_ok    <= 1'b1;
      header_length   <= '0;
      stored_crc      <= '0;
    end else if (accept && active) begin
      byte_position   <= byte_position_next;
      crc_register    <= crc_register_next;
      boot_sig_ok     <= boot_sig_ok_next;
      protective_seen <= protective_seen_next;
      signature_ok    <= signature_ok_next;
      header_length   <= header_length_next;
      stored_crc      <= stored_crc_next;
    end
  end

  // Result register: loads on the last byte, drains on the sink handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && active && last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && active && last_byte) begin
      table_valid  <= (code == FAIL_NONE);
      fail_code    <= code;
      computed_crc <= size_ok ? crc_final : 32'd0;
    end
  end

  assign m_tdata = {4'd0, computed_crc, fail_code, table_valid};

  // A verdict only passes when no check failed.
  a_valid_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (table_valid == (fail_code == FAIL_NONE)))
    else $error("table_valid disagrees with fail_code");

  // A bad header size reports a zero CRC.
  a_size_fail_zero_crc: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fail_code == FAIL_SIZE) |-> (computed_crc == 32'd0))
    else $error("size failure with nonzero CRC");

  // A fresh verdict appears only once both sectors have been counted.
  a_result_at_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> (byte_position == pos_t'(END_BYTES)))
    else $error("result without a complete sector pair");

endmodule

### verif/gpt_header_validator_tb.sv
// Self-checking testbench for gpt_header_validator: sends sector 0 and sector 1
// images as byte requests and checks every verdict against its own predictor.
// Depends on gpt_hv_pkg and gpt_header_validator; needs no files or arguments.
`timescale 1ns / 100ps

module gpt_header_validator_tb;
  import gpt_hv_pkg::*;

  // Faults that can be planted in an otherwise well-formed disk image.
  localparam int unsigned FAULT_BOOT_LO   = 1 << 0;
  localparam int unsigned FAULT_BOOT_HI   = 1 << 1;
  localparam int unsigned FAULT_NO_PROT   = 1 << 2;
  localparam int unsigned FAULT_SIGNATURE = 1 << 3;
  localparam int unsigned FAULT_CRC       = 1 << 4;

  localparam int RESET_CYCLES     = 12;
  localparam int DRAIN_CYCLES     = 20;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int MAX_REPORTS      = 40;
  localparam int IMAGES_PER_PHASE = 10;

  typedef struct packed {
    logic        valid;
    fail_code_t  code;
    logic [31:0] crc;
  } verdict_t;

  // Tracks the header check byte by byte and holds the verdicts still owed.
  class gpt_verdict_scoreboard;
    pos_t        bytes_taken;
    logic [31:0] crc_acc;
    bit          boot_ok;
    bit          prot_seen;
    bit          sig_ok;
    logic [31:0] hdr_len;
    logic [31:0] crc_field;
    verdict_t    verdict_q[$];
    int unsigned verdicts_due;
    int unsigned verdicts_seen;
    int unsigned mismatches;
    int unsigned bytes_noted;
    int unsigned bytes_ignored;

    function new();
      restart_check();
      verdicts_due  = 0;
      verdicts_seen = 0;
      mismatches    = 0;
      bytes_noted   = 0;
      bytes_ignored = 0;
    endfunction

    function void restart_check();
      bytes_taken = '0;
      crc_acc     = CRC_INIT;
      boot_ok     = 1'b0;
      prot_seen   = 1'b0;
      sig_ok      = 1'b1;
      hdr_len     = '0;
      crc_field   = '0;
    endfunction

    // Reflected CRC-32 over one byte, one bit per pass.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      repeat (8) r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
      return r;
    endfunction

    function void note_request(logic [7:0] b, logic restart);
      int          off;
      int          rel;
      logic [7:0]  crc_in;
      logic [31:0] crc_out;
      bit          size_ok;
      verdict_t    v;
      bytes_noted++;
      if (restart) restart_check();
      if (bytes_taken >= pos_t'(END_BYTES)) begin
        bytes_ignored++;
        return;
      end
      if (bytes_taken < pos_t'(SECTOR_BYTES)) begin
        rel = int'(bytes_taken) - MBR_TABLE_START;
        if (bytes_taken == pos_t'(BOOT_SIG_AT)) boot_ok = (b == BOOT_LO);
        else if (bytes_taken == pos_t'(BOOT_SIG_AT + 1)) boot_ok = boot_ok && (b == BOOT_HI);
        if (rel >= 0 && rel < 64 && rel % 16 == 4 && b == TYPE_PROT) prot_seen = 1'b1;
      end else begin
        off    = int'(bytes_taken) - SECTOR_BYTES;
        crc_in = b;
        if (off < 8 && b != EFI_SIG[8*off +: 8]) sig_ok = 1'b0;
        if (off >= 12 && off < 16) hdr_len |= 32'(b) << (8 * (off - 12));
        if (off >= 16 && off < 20) begin
          crc_field |= 32'(b) << (8 * (off - 16));
          crc_in = 8'h00;
        end
        if (off < 16 || 32'(off) < hdr_len) crc_acc = crc_step(crc_acc, crc_in);
      end
      bytes_taken = bytes_taken + 1'b1;
      if (bytes_taken == pos_t'(END_BYTES)) begin
        crc_out = crc_acc ^ CRC_INIT;
        size_ok = hdr_len >= 32'(HDR_MIN) && hdr_len <= 32'(SECTOR_BYTES);
        if (!boot_ok) v.code = FAIL_BOOT_SIG;
        else if (!prot_seen) v.code = FAIL_NO_PROT;
        else if (!sig_ok) v.code = FAIL_SIGNATURE;
        else if (!size_ok) v.code = FAIL_SIZE;
        else if (crc_out != crc_field) v.code = FAIL_CRC;
        else v.code = FAIL_NONE;
        v.valid = (v.code == FAIL_NONE);
        v.crc   = size_ok ? crc_out : 32'd0;
        verdict_q.push_back(v);
        verdicts_due++;
      end
    endfunction

    function void check_verdict(logic [M_DATA_W-1:0] word);
      verdict_t exp;
      bit       bad;
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: verdict with none expected, got %010h", $time, word);
        return;
      end
      exp = verdict_q.pop_front();
      bad = 1'b0;
      if (word[0] !== exp.valid) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: table_valid expected %0d, got %0d", $time, exp.valid, word[0]);
      end
      if (word[3:1] !== exp.code) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: fail_code expected %0d, got %0d", $time, exp.code, word[3:1]);
      end
      if (word[35:4] !== exp.crc) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: computed_crc expected %08h, got %08h", $time, exp.crc, word[35:4]);
      end
      if (word[M_DATA_W-1:36] !== '0) begin
        bad = 1'b1;
        if (mismatches < MAX_REPORTS)
          $display("%0t: pad bits expected 0, got %0h", $time, word[M_DATA_W-1:36]);
      end
      if (bad) mismatches++;
    endfunction
  endclass

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // Per-cycle chances, in percent, that the sender holds back a request and
  // that the sink refuses a verdict. The main sequence changes them per phase.
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;

  // Sector 0 followed by sector 1, as it will be streamed.
  logic [7:0] disk_image [END_BYTES];

  gpt_verdict_scoreboard sb;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gpt_header_validator i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] data_byte
    .s_tuser  (s_tuser),   // [0] restart
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // [0] table_valid, [3:1] fail_code, [35:4] computed_crc
  );

  // The sink decides afresh every cycle whether it takes a verdict.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Both handshakes are sampled at the edge, before any nonblocking update of
  // this step lands, so the values seen are exactly the ones the block saw.
  // Requests are noted before verdicts are checked; a verdict is registered and
  // so always arrives after the last byte of its image.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_verdict(m_tdata);
    end
  end

  // Presents one byte request and returns at the edge where it is taken. A
  // random gap in front of it drops tvalid; without a gap tvalid stays high
  // from one request into the next.
  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
  endtask

  // Streams the first n_bytes of the image; only byte 0 may carry restart.
  task automatic send_image(input int n_bytes, input bit with_restart);
    for (int i = 0; i < n_bytes; i++) send_byte(disk_image[i], with_restart && i == 0);
  endtask

  // Bytes after a finished image without restart must be swallowed silently.
  task automatic send_trailer(input int n_bytes);
    for (int i = 0; i < n_bytes; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic fill_image(input logic [7:0] value);
    foreach (disk_image[i]) disk_image[i] = value;
  endtask

  // Builds a random image whose checks all pass for a legal hdr_size, then plants
  // the requested faults. The stored CRC is always computed for the header size
  // given, so a CRC fault is the only thing that breaks it.
  task automatic make_image(input logic [31:0] hdr_size, input int prot_entry,
                            input int unsigned faults);
    int          crc_len;
    int          type_at;
    logic [7:0]  v;
    logic [31:0] c;
    foreach (disk_image[i]) disk_image[i] = 8'($urandom);
    if ((faults & FAULT_NO_PROT) != 0) begin
      for (int k = 0; k < 4; k++) begin
        do v = 8'($urandom); while (v == TYPE_PROT);
        disk_image[MBR_TABLE_START + 16*k + 4] = v;
      end
      // A type value on the status byte of an entry must not count.
      disk_image[MBR_TABLE_START + 16*prot_entry] = TYPE_PROT;
    end else begin
      type_at = MBR_TABLE_START + 16*prot_entry + 4;
      disk_image[type_at] = TYPE_PROT;
    end
    disk_image[BOOT_SIG_AT]     = BOOT_LO;
    disk_image[BOOT_SIG_AT + 1] = BOOT_HI;
    if ((faults & FAULT_BOOT_LO) != 0) disk_image[BOOT_SIG_AT] ^= 8'($urandom_range(1, 255));
    if ((faults & FAULT_BOOT_HI) != 0)
      disk_image[BOOT_SIG_AT + 1] ^= 8'($urandom_range(1, 255));

    for (int i = 0; i < 8; i++) disk_image[SECTOR_BYTES + i] = EFI_SIG[8*i +: 8];
    if ((faults & FAULT_SIGNATURE) != 0)
      disk_image[SECTOR_BYTES + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 4; i++) begin
      disk_image[SECTOR_BYTES + 12 + i] = hdr_size[8*i +: 8];
      disk_image[SECTOR_BYTES + 16 + i] = 8'h00;
    end

    // The CRC always covers the first 16 bytes and never runs past the sector.
    if (hdr_size > 32'(SECTOR_BYTES)) crc_len = SECTOR_BYTES;
    else if (hdr_size < 32'd16) crc_len = 16;
    else crc_len = int'(hdr_size);
    c = CRC_INIT;
    for (int i = 0; i < crc_len; i++)
      c = gpt_verdict_scoreboard::crc_step(c, disk_image[SECTOR_BYTES + i]);
    c ^= CRC_INIT;
    for (int i = 0; i < 4; i++) disk_image[SECTOR_BYTES + 16 + i] = c[8*i +: 8];
    if ((faults & FAULT_CRC) != 0)
      disk_image[SECTOR_BYTES + 16 + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
  endtask

  // Legal sizes lean toward both edges of the range; illegal ones land just
  // below the minimum, just above a sector, or anywhere in the upper bits.
  function automatic logic [31:0] pick_hdr_size(input bit legal);
    if (legal) begin
      case ($urandom_range(3))
        0:       return 32'(HDR_MIN);
        1:       return 32'(SECTOR_BYTES);
        default: return 32'($urandom_range(HDR_MIN, SECTOR_BYTES));
      endcase
    end
    case ($urandom_range(3))
      0:       return 32'($urandom_range(0, HDR_MIN - 1));
      1:       return 32'($urandom_range(SECTOR_BYTES + 1, 4096));
      2:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      default: return $urandom | 32'h0001_0000;
    endcase
  endfunction

  // One random case: mostly a full image with a few random faults, sometimes
  // cut short by the restart of the next image, sometimes followed by bytes
  // that the block must ignore.
  task automatic random_case(output bit full_image);
    int unsigned faults;
    int          pick;
    faults = 0;
    if ($urandom_range(99) < 8) faults |= FAULT_BOOT_LO;
    if ($urandom_range(99) < 8) faults |= FAULT_BOOT_HI;
    if ($urandom_range(99) < 8) faults |= FAULT_NO_PROT;
    if ($urandom_range(99) < 8) faults |= FAULT_SIGNATURE;
    if ($urandom_range(99) < 8) faults |= FAULT_CRC;
    make_image(pick_hdr_size($urandom_range(99) >= 10), $urandom_range(0, 3), faults);
    pick = $urandom_range(99);
    full_image = (pick >= 10);
    if (!full_image) begin
      send_image($urandom_range(1, END_BYTES - 1), 1'b1);
    end else begin
      send_image(END_BYTES, 1'b1);
      if (pick < 25) send_trailer($urandom_range(1, 40));
    end
  endtask

  // Hard stop in case the block stops taking requests or never answers.
  initial begin
    #30_000_000;
    $display("%0t: run timed out", $time);
    $display("gpt_header_validator_tb failed");
    $finish;
  end

  initial begin
    int full_count;
    bit full_image;
    int guard;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling. The first image after reset has no restart
    // mark: the block must treat its first byte as byte 0 anyway.
    make_image(32'(HDR_MIN), 0, 0);
    send_image(END_BYTES, 1'b0);
    // Bytes past the end without restart give no verdict.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_trailer(6);
    make_image(32'(SECTOR_BYTES), 3, 0);
    send_image(END_BYTES, 1'b1);
    // Header sizes beyond both limits.
    make_image(32'(HDR_MIN - 1), 1, 0);
    send_image(END_BYTES, 1'b1);
    make_image(32'(SECTOR_BYTES + 1), 2, 0);
    send_image(END_BYTES, 1'b1);
    make_image(32'd0, 0, 0);
    send_image(END_BYTES, 1'b1);
    make_image(32'hFFFF_FFFF, 3, 0);
    send_image(END_BYTES, 1'b1);
    // One of each failing check on its own.
    make_image(32'd128, 1, FAULT_BOOT_LO);
    send_image(END_BYTES, 1'b1);
    make_image(32'd128, 2, FAULT_BOOT_HI);
    send_image(END_BYTES, 1'b1);
    make_image(32'd128, 0, FAULT_NO_PROT);
    send_image(END_BYTES, 1'b1);
    make_image(32'd128, 3, FAULT_SIGNATURE);
    send_image(END_BYTES, 1'b1);
    make_image(32'd128, 1, FAULT_CRC);
    send_image(END_BYTES, 1'b1);
    // Several failures at once: the earliest check in order must win.
    make_image(32'd200, 2, FAULT_BOOT_LO | FAULT_CRC);
    send_image(END_BYTES, 1'b1);
    make_image(32'd16, 0, FAULT_SIGNATURE);
    send_image(END_BYTES, 1'b1);
    make_image(32'd300, 3, FAULT_NO_PROT | FAULT_SIGNATURE | FAULT_CRC);
    send_image(END_BYTES, 1'b1);
    // Byte extremes across every field.
    fill_image(8'h00);
    send_image(END_BYTES, 1'b1);
    fill_image(8'hFF);
    send_image(END_BYTES, 1'b1);
    // A restart partway through drops the running check.
    make_image(32'd300, 2, 0);
    send_image(700, 1'b1);
    make_image(32'd200, 2, 0);
    send_image(END_BYTES, 1'b1);

    // Random part: four handshake phases, each running until enough complete
    // images have gone through.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 51;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 51;
        end
        default: begin
          sender_idle_pct    = 32;
          receiver_stall_pct = 32;
        end
      endcase
      full_count = 0;
      while (full_count < IMAGES_PER_PHASE) begin
        random_case(full_image);
        if (full_image) full_count++;
      end
    end
    s_tvalid <= 1'b0;

    // Let outstanding verdicts drain, then watch a little longer for strays.
    guard = 0;
    while (sb.verdict_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.verdict_q.size() != 0) begin
      $display("%0t: %0d expected verdicts never arrived", $time, sb.verdict_q.size());
      sb.mismatches += sb.verdict_q.size();
    end

    $display("Checked %0d of %0d verdicts from %0d byte requests (%0d past an image end).",
             sb.verdicts_seen, sb.verdicts_due, sb.bytes_noted, sb.bytes_ignored);
    $display("Directed edge cases, then random images under four idle and stall mixes.");
    if (sb.mismatches == 0) begin
      $display("gpt_header_validator_tb passed");
    end else begin
      $display("gpt_header_validator_tb failed");
    end
    $finish;
  end

endmodule
